/* src/vrhd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrhd_pkg
// Shared constants and types of the versioned record header decoder.
// ----------------------------------------------------------------------------
package vrhd_pkg;

  localparam int unsigned V0HeaderSize = 15;
  localparam int unsigned V1HeaderSize = 20;
  localparam int unsigned V1Alignment  = 8;
  localparam int unsigned PosWidth     = 34;
  localparam int unsigned QueueDepthDefault = 4;

  localparam logic KindPayload = 1'b0;
  localparam logic KindSummary = 1'b1;

  // One queue entry: the results that one input byte causes.
  typedef struct packed {
    logic        pay_vld;
    logic        sum_vld;
    logic [7:0]  pay_value;
    logic [31:0] pay_index;
    logic        status;
    logic        version;
    logic [31:0] rec_ident;
    logic [63:0] timestamp;
    logic [31:0] body_len;
  } vrhd_op_t;

endpackage

/* src/vrhd_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrhd_front
// Accepts record bytes, tracks the header fields and the error state, and
// classifies each byte into the results it causes.
// ----------------------------------------------------------------------------
module vrhd_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        data_byte_i,
  input  logic              end_of_record_i,
  input  logic              q_full_i,
  output logic              push_o,
  output vrhd_pkg::vrhd_op_t op_o
);
  import vrhd_pkg::*;

  localparam logic [PosWidth-1:0] PosMax    = '1;
  localparam logic [PosWidth-1:0] AlignMask = PosWidth'(V1Alignment - 1);

  logic [PosWidth-1:0] pos_q, pos_d;
  logic                ver_q, ver_d;
  logic                err_q, err_d;
  logic [31:0]         id_q, id_d;
  logic [63:0]         time_q, time_d;
  logic [31:0]         len_q, len_d;

  logic                accept;
  logic                pos_small;
  logic [4:0]          pos_lo;
  logic [PosWidth-1:0] hdr;
  logic [PosWidth-1:0] data_end;
  logic [PosWidth-1:0] total;
  logic                in_body;
  logic                emit_pay;
  logic                err_fin;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i & ~q_full_i;
  assign pos_small  = (pos_q[PosWidth-1:5] == '0);
  assign pos_lo     = pos_q[4:0];

  // Header size and payload end only matter once the header is complete, when
  // the version and length registers already hold their final values.
  assign hdr      = ver_q ? PosWidth'(V1HeaderSize) : PosWidth'(V0HeaderSize);
  assign data_end = hdr + PosWidth'(len_q);
  assign total    = ver_q ? ((data_end + AlignMask) & ~AlignMask) : data_end;
  assign in_body  = (pos_q >= hdr);
  assign emit_pay = in_body & (pos_q < data_end) & ~err_q;

  always_comb begin
    ver_d  = ver_q;
    err_d  = err_q;
    id_d   = id_q;
    time_d = time_q;
    len_d  = len_q;
    if (pos_q == '0) begin
      if (data_byte_i > 8'd1) err_d = 1'b1;
      ver_d = (data_byte_i == 8'd1);
    end else if (!ver_q) begin
      if (pos_small) begin
        for (int k = 0; k < 4; k++) begin
          if (pos_lo == 5'(k + 1)) id_d[8*k +: 8] = id_q[8*k +: 8] | data_byte_i;
        end
        for (int k = 0; k < 8; k++) begin
          if (pos_lo == 5'(k + 5)) time_d[8*k +: 8] = time_q[8*k +: 8] | data_byte_i;
        end
        for (int k = 0; k < 2; k++) begin
          if (pos_lo == 5'(k + 13)) len_d[8*k +: 8] = len_q[8*k +: 8] | data_byte_i;
        end
      end
    end else if (pos_small) begin
      if (pos_lo <= 5'd3) begin
        if (data_byte_i != 8'd0) err_d = 1'b1;
      end else if (pos_lo <= 5'd7) begin
        id_d = {id_q[23:0], data_byte_i};
      end else if (pos_lo <= 5'd15) begin
        time_d = {time_q[55:0], data_byte_i};
      end else if (pos_lo <= 5'd19) begin
        len_d = {len_q[23:0], data_byte_i};
      end
    end

    // Bytes past the payload are padding, and bytes past the padding are extra.
    if (in_body && (pos_q >= data_end)) begin
      if (pos_q < total) begin
        if (data_byte_i != 8'd0) err_d = 1'b1;
      end else begin
        err_d = 1'b1;
      end
    end

    err_fin = err_d;
    if (end_of_record_i && (!in_body || ((pos_q + 1'b1) != total))) err_fin = 1'b1;

    pos_d = (pos_q != PosMax) ? pos_q + 1'b1 : pos_q;
  end

  always_comb begin
    op_o                = '0;
    op_o.pay_vld        = emit_pay;
    op_o.sum_vld        = end_of_record_i;
    op_o.pay_value      = data_byte_i;
    op_o.pay_index      = 32'(pos_q - hdr);
    op_o.status         = err_fin;
    if (!err_fin) begin
      op_o.version        = ver_d;
      op_o.rec_ident      = id_d;
      op_o.timestamp      = time_d;
      op_o.body_len       = len_d;
    end
  end

  assign push_o = accept & (emit_pay | end_of_record_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      ver_q  <= 1'b0;
      err_q  <= 1'b0;
      id_q   <= '0;
      time_q <= '0;
      len_q  <= '0;
    end else if (accept) begin
      if (end_of_record_i) begin
        pos_q  <= '0;
        ver_q  <= 1'b0;
        err_q  <= 1'b0;
        id_q   <= '0;
        time_q <= '0;
        len_q  <= '0;
      end else begin
        pos_q  <= pos_d;
        ver_q  <= ver_d;
        err_q  <= err_d;
        id_q   <= id_d;
        time_q <= time_d;
        len_q  <= len_d;
      end
    end
  end

endmodule

/* src/vrhd_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrhd_queue
// Short first-in first-out queue of classified bytes between front and back.
// ----------------------------------------------------------------------------
module vrhd_queue #(
  parameter int unsigned QueueDepth = vrhd_pkg::QueueDepthDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  vrhd_pkg::vrhd_op_t push_op_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               empty_o,
  output vrhd_pkg::vrhd_op_t head_o
);
  import vrhd_pkg::*;

  localparam int unsigned PtrWidth = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntWidth = $clog2(QueueDepth + 1);

  vrhd_op_t              mem_q [QueueDepth];
  logic [PtrWidth-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntWidth-1:0]   count_q;

  assign full_o  = (count_q == CntWidth'(QueueDepth));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_op_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrWidth'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrWidth'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

/* src/vrhd_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrhd_back
// Turns queue entries into result transactions, payload item before summary,
// through a registered output stage.
// ----------------------------------------------------------------------------
module vrhd_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               empty_i,
  input  vrhd_pkg::vrhd_op_t head_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               item_kind_o,
  output logic [7:0]         payload_value_o,
  output logic [31:0]        payload_index_o,
  output logic               status_o,
  output logic               format_version_o,
  output logic [31:0]        rec_ident_o,
  output logic [63:0]        timestamp_o,
  output logic [31:0]        body_len_o,
  output logic               last_of_run_o
);
  import vrhd_pkg::*;

  logic        out_valid_q;
  logic        pay_sent_q;
  logic        load;
  logic        send_pay;
  logic        kind_q;
  logic [7:0]  value_q;
  logic [31:0] index_q;
  logic        status_q;
  logic        version_q;
  logic [31:0] id_q;
  logic [63:0] time_q;
  logic [31:0] len_q;
  logic        last_q;

  assign load     = ~empty_i & (~out_valid_q | ~out_stall_i);
  assign send_pay = head_i.pay_vld & ~pay_sent_q;
  // An entry with both results stays at the head until its summary has gone.
  assign pop_o    = load & (~send_pay | ~head_i.sum_vld);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pay_sent_q  <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (load) pay_sent_q <= send_pay & head_i.sum_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      if (send_pay) begin
        kind_q    <= KindPayload;
        value_q   <= head_i.pay_value;
        index_q   <= head_i.pay_index;
        status_q  <= 1'b0;
        version_q <= 1'b0;
        id_q      <= '0;
        time_q    <= '0;
        len_q     <= '0;
        last_q    <= ~head_i.sum_vld;
      end else begin
        kind_q    <= KindSummary;
        value_q   <= '0;
        index_q   <= '0;
        status_q  <= head_i.status;
        version_q <= head_i.version;
        id_q      <= head_i.rec_ident;
        time_q    <= head_i.timestamp;
        len_q     <= head_i.body_len;
        last_q    <= 1'b1;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign item_kind_o      = kind_q;
  assign payload_value_o  = value_q;
  assign payload_index_o  = index_q;
  assign status_o         = status_q;
  assign format_version_o = version_q;
  assign rec_ident_o      = id_q;
  assign timestamp_o      = time_q;
  assign body_len_o       = len_q;
  assign last_of_run_o    = last_q;

endmodule

/* src/versioned_record_header_decoder_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// versioned_record_header_decoder_top
// Byte-stream decoder for version 0 and version 1 record headers.
// ----------------------------------------------------------------------------
// Input channel: one record byte per transaction on data_byte_i, with
// end_of_record_i high on the final byte. A byte is taken when in_valid_i is
// high and in_stall_o is low. Output channel: one result per transaction,
// taken when out_valid_o is high and out_stall_i is low.
// Each payload byte produces a payload item unless an earlier byte of the
// record set the error flag; the final byte also produces a summary with
// status, version, id, timestamp and length. A final byte that is also
// payload gives two results, payload first. The front stage accepts one byte
// per cycle while the queue is not full; a result passes through the queue
// and the output register; the output delivers one result per cycle while
// out_stall_i is low. When the receiver stalls, results collect in a queue
// of QueueDepth entries; the input stalls only once that queue is full.
// Reset clears the byte position, header fields and error flag, and empties
// the queue and the output register. After each final byte the front stage
// also returns its position, header fields and error flag to that state.
// ----------------------------------------------------------------------------
module versioned_record_header_decoder_top #(
  parameter int unsigned QueueDepth = vrhd_pkg::QueueDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_record_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        item_kind_o,
  output logic [7:0]  payload_value_o,
  output logic [31:0] payload_index_o,
  output logic        status_o,
  output logic        format_version_o,
  output logic [31:0] rec_ident_o,
  output logic [63:0] timestamp_o,
  output logic [31:0] body_len_o,
  output logic        last_of_run_o
);
  import vrhd_pkg::*;

  logic     q_full;
  logic     q_empty;
  logic     push;
  logic     pop;
  vrhd_op_t push_op;
  vrhd_op_t head_op;

  vrhd_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .data_byte_i     (data_byte_i),
    .end_of_record_i (end_of_record_i),
    .q_full_i        (q_full),
    .push_o          (push),
    .op_o            (push_op)
  );

  vrhd_queue #(
    .QueueDepth (QueueDepth)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_op_i (push_op),
    .full_o    (q_full),
    .pop_i     (pop),
    .empty_o   (q_empty),
    .head_o    (head_op)
  );

  vrhd_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .empty_i          (q_empty),
    .head_i           (head_op),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .item_kind_o      (item_kind_o),
    .payload_value_o  (payload_value_o),
    .payload_index_o  (payload_index_o),
    .status_o         (status_o),
    .format_version_o (format_version_o),
    .rec_ident_o      (rec_ident_o),
    .timestamp_o      (timestamp_o),
    .body_len_o       (body_len_o),
    .last_of_run_o    (last_of_run_o)
  );

endmodule
